FILE: sv/sed_pkg.sv
// Shared types and constants for the RGB Sobel edge stream block.
// Used by sed_mag and sobel_edge_rgb_stream; depends on nothing else.
package sed_pkg;

  localparam int CH_W       = 8;   // one color channel
  localparam int PIX_W      = 24;  // red 23..16, green 15..8, blue 7..0
  localparam int FW_W       = 11;  // frame_width register
  localparam int FH_W       = 13;  // frame_height register
  localparam int CFG_DATA_W = 13;  // widest register
  localparam int GRAD_W     = 11;  // signed gradient, magnitude up to 1020
  localparam int SUMSQ_W    = 21;  // gx^2 + gy^2, at most 2080800
  localparam int ODD_W      = 9;   // 2n-1 for n up to 255
  localparam int STEP_W     = 3;   // bit position of the root search

  localparam logic [FW_W-1:0] RESET_FRAME_WIDTH  = 11'd1024;
  localparam logic [FH_W-1:0] RESET_FRAME_HEIGHT = 13'd768;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic            func;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red_edge;
    logic [CH_W-1:0] green_edge;
    logic [CH_W-1:0] blue_edge;
    logic            frame_end;
  } out_item_t;

  // One channel of the 3x3 window, row-major, top-left first.
  typedef logic [8:0][CH_W-1:0] win_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_ADDR,
    T_SHIFT,
    T_CALC
  } top_state_t;

  typedef enum logic [1:0] {
    M_IDLE,
    M_SQ,
    M_ROOT,
    M_DONE
  } mag_state_t;

endpackage

FILE: sv/sobel_edge_rgb_stream.sv
// Top level of the RGB Sobel edge stream: handshakes, line stores, window
// and frame counters. Depends on sed_pkg and sed_mag.
//
// Pixels enter in raster order; each pixel yields per channel the rounded
// Sobel magnitude, clamped at 255, with neighbors outside the frame read as
// zero. Output k leaves when input k+W+1 is taken, so after the last pixel
// W+1 drain beats (func = 1) flush the rest; a drain sent earlier is dropped,
// and frame_end marks the last output of the frame. An item is taken only
// after the previous one is done. One that yields an edge pixel runs the
// 8-step square root search of the magnitude units, then waits while the
// previous output is held by a low out_ready; an early drain skips the
// line stores, block memories with a registered read that every other item
// reads once and writes once. Writing either register restarts the frame.
// The line stores need no clearing after reset.
module sobel_edge_rgb_stream #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sed_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sed_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  sed_pkg::cfg_reg_t                cfg_index,
  input  logic [sed_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import sed_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int DIM_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int TOT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);
  localparam int RST_W = (int'(RESET_FRAME_WIDTH) > MAX_WIDTH) ?
                         MAX_WIDTH : int'(RESET_FRAME_WIDTH);
  localparam int RST_H = (int'(RESET_FRAME_HEIGHT) > MAX_HEIGHT) ?
                         MAX_HEIGHT : int'(RESET_FRAME_HEIGHT);

  top_state_t               state_r, state_nxt;
  in_item_t                 item_r;
  logic [DIM_W-1:0]         w_r, w_cfg;
  logic [HGT_W-1:0]         h_r, h_cfg;
  logic [TOT_W-1:0]         total_r;
  logic [POS_W-1:0]         pos_r;
  logic [COL_W-1:0]         col_r;
  logic [ROW_W-1:0]         row_r;
  logic [TOT_W-1:0]         ocnt_r;
  logic                     last_r;
  logic [PIX_W-1:0]         x_r, x_nxt;
  logic [PIX_W-1:0]         store_a_mem [MAX_WIDTH];
  logic [PIX_W-1:0]         store_b_mem [MAX_WIDTH];
  logic [PIX_W-1:0]         top_rd_r, mid_rd_r;
  logic [8:0][PIX_W-1:0]    window_r, win_shift;
  logic                     in_range, ignore, emit, last_out;
  logic [ROW_W-1:0]         r_base;
  logic [DIM_W-1:0]         c_base, col_plus;
  logic [2:0]               row_ok, col_ok;
  win_t                     mag_win [3];
  logic [2:0]               mag_done_ch;
  logic [CH_W-1:0]          mag_res [3];
  logic                     mag_done;
  logic                     rd_en, wr_en, mag_start, out_load, advance;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  // Registers are stored already clamped to 1..MAX.
  always_comb begin
    if (cfg_wdata[FW_W-1:0] == '0) begin
      w_cfg = DIM_W'(1);
    end else if (int'(cfg_wdata[FW_W-1:0]) > MAX_WIDTH) begin
      w_cfg = DIM_W'(MAX_WIDTH);
    end else begin
      w_cfg = DIM_W'(cfg_wdata[FW_W-1:0]);
    end
    if (cfg_wdata[FH_W-1:0] == '0) begin
      h_cfg = HGT_W'(1);
    end else if (int'(cfg_wdata[FH_W-1:0]) > MAX_HEIGHT) begin
      h_cfg = HGT_W'(MAX_HEIGHT);
    end else begin
      h_cfg = HGT_W'(cfg_wdata[FH_W-1:0]);
    end
  end

  // Per-item decisions.
  always_comb begin
    in_range = pos_r < POS_W'(total_r);
    ignore   = item_r.func && in_range;
    x_nxt    = (in_range && !item_r.func) ?
               {item_r.red_in, item_r.green_in, item_r.blue_in} : '0;
    emit     = pos_r >= (POS_W'(w_r) + POS_W'(1));
    last_out = (ocnt_r + TOT_W'(1)) == total_r;
    col_plus = DIM_W'(col_r) + DIM_W'(1);
  end

  // Window after this item's shift, and the border mask of its center.
  always_comb begin
    for (int rr = 0; rr < 3; rr++) begin
      win_shift[rr*3]     = window_r[rr*3 + 1];
      win_shift[rr*3 + 1] = window_r[rr*3 + 2];
    end
    win_shift[2] = top_rd_r;
    win_shift[5] = mid_rd_r;
    win_shift[8] = x_r;

    if (col_r != '0) begin
      r_base = row_r - ROW_W'(1);
      c_base = DIM_W'(col_r) - DIM_W'(1);
    end else begin
      r_base = row_r - ROW_W'(2);
      c_base = w_r - DIM_W'(1);
    end
    row_ok[0] = r_base != '0;
    row_ok[1] = 1'b1;
    row_ok[2] = (r_base + ROW_W'(1)) < ROW_W'(h_r);
    col_ok[0] = c_base != '0;
    col_ok[1] = 1'b1;
    col_ok[2] = (c_base + DIM_W'(1)) < w_r;

    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 9; i++) begin
        mag_win[ch][i] = (row_ok[i/3] && col_ok[i%3]) ?
                         win_shift[i][PIX_W-1-CH_W*ch -: CH_W] : '0;
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_mag
    sed_mag u_mag (
      .clk   (clk),
      .rst_n (rst_n),
      .start (mag_start),
      .win   (mag_win[g]),
      .done  (mag_done_ch[g]),
      .mag   (mag_res[g])
    );
  end

  assign mag_done = &mag_done_ch;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE:  if (in_valid) state_nxt = T_ADDR;
      T_ADDR:  state_nxt = ignore ? T_IDLE : T_SHIFT;
      T_SHIFT: state_nxt = emit ? T_CALC : T_IDLE;
      T_CALC:  if (mag_done && (!out_valid_r || out_ready)) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == T_IDLE);
    rd_en     = (state_r == T_ADDR) && !ignore;
    wr_en     = (state_r == T_SHIFT);
    advance   = (state_r == T_SHIFT);
    mag_start = (state_r == T_SHIFT) && emit;
    out_load  = (state_r == T_CALC) && mag_done && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r     <= DIM_W'(RST_W);
      h_r     <= HGT_W'(RST_H);
      total_r <= TOT_W'(RST_W * RST_H);
    end else begin
      if (cfg_we && cfg_index == CFG_FRAME_WIDTH) begin
        w_r <= w_cfg;
      end
      if (cfg_we && cfg_index == CFG_FRAME_HEIGHT) begin
        h_r <= h_cfg;
      end
      total_r <= TOT_W'(w_r) * TOT_W'(h_r);
    end
  end

  // Frame position counters and the window; a register write restarts them.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      pos_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
      ocnt_r   <= '0;
      window_r <= '0;
    end else if (advance) begin
      if (emit && last_out) begin
        pos_r    <= '0;
        col_r    <= '0;
        row_r    <= '0;
        ocnt_r   <= '0;
        window_r <= '0;
      end else begin
        pos_r    <= pos_r + POS_W'(1);
        window_r <= win_shift;
        if (col_plus >= w_r) begin
          col_r <= '0;
          row_r <= row_r + ROW_W'(1);
        end else begin
          col_r <= COL_W'(col_plus);
        end
        if (emit) begin
          ocnt_r <= ocnt_r + TOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (state_r == T_ADDR) begin
      x_r <= x_nxt;
    end
    if (mag_start) begin
      last_r <= last_out;
    end
    if (out_load) begin
      out_data_r.red_edge   <= mag_res[0];
      out_data_r.green_edge <= mag_res[1];
      out_data_r.blue_edge  <= mag_res[2];
      out_data_r.frame_end  <= last_r;
    end
  end

  // Line stores: read in ADDR, written back in SHIFT at the same column.
  // Items are handled one at a time, so a read never overlaps a pending write.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      top_rd_r <= store_a_mem[col_r];
      mid_rd_r <= store_b_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_a_mem[col_r] <= mid_rd_r;
      store_b_mem[col_r] <= x_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> $past(rd_en))
    else $error("line store written without a read of the column first");

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    DIM_W'(col_r) < w_r)
    else $error("column counter reached the frame width");

  a_outputs_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r < total_r)
    else $error("output count ran past the frame size");

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= (POS_W'(total_r) + POS_W'(w_r)))
    else $error("position ran past the last drain beat of the frame");

endmodule

FILE: sv/sed_mag.sv
// Sobel magnitude of one color channel over a masked 3x3 window.
// Gradients, squared sum, then an 8-step rounded square root search.
// Depends on sed_pkg.
module sed_mag (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  sed_pkg::win_t           win,
  output logic                    done,
  output logic [sed_pkg::CH_W-1:0] mag
);
  import sed_pkg::*;

  mag_state_t                  state_r, state_nxt;
  logic signed [GRAD_W-1:0]    gx_r, gy_r;
  logic [GRAD_W-1:0]           gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [2*GRAD_W-1:0]  sq_x, sq_y;
  logic [SUMSQ_W-1:0]          sumsq_r;
  logic [STEP_W-1:0]           step_r;
  logic [CH_W-1:0]             res_r;
  logic [CH_W-1:0]             trial;
  logic [ODD_W-1:0]            odd;
  logic [2*ODD_W-1:0]          odd_sq;
  logic [SUMSQ_W+1:0]          s4;
  logic                        fits;

  always_comb begin
    gx_pos = GRAD_W'(win[2]) + GRAD_W'({win[5], 1'b0}) + GRAD_W'(win[8]);
    gx_neg = GRAD_W'(win[0]) + GRAD_W'({win[3], 1'b0}) + GRAD_W'(win[6]);
    gy_pos = GRAD_W'(win[6]) + GRAD_W'({win[7], 1'b0}) + GRAD_W'(win[8]);
    gy_neg = GRAD_W'(win[0]) + GRAD_W'({win[1], 1'b0}) + GRAD_W'(win[2]);
  end

  assign sq_x = gx_r * gx_r;
  assign sq_y = gy_r * gy_r;

  // Largest n with (2n-1)^2 <= 4s is the rounded root; found MSB first.
  assign trial  = res_r | (CH_W'(1) << step_r);
  assign odd    = {trial, 1'b0} - ODD_W'(1);
  assign odd_sq = odd * odd;
  assign s4     = {sumsq_r, 2'b00};
  assign fits   = (SUMSQ_W+2)'(odd_sq) <= s4;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      M_IDLE:  if (start) state_nxt = M_SQ;
      M_SQ:    state_nxt = M_ROOT;
      M_ROOT:  if (step_r == '0) state_nxt = M_DONE;
      M_DONE:  if (start) state_nxt = M_SQ;
      default: state_nxt = M_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == M_DONE);
    mag  = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      gx_r <= signed'(gx_pos - gx_neg);
      gy_r <= signed'(gy_pos - gy_neg);
    end
    if (state_r == M_SQ) begin
      sumsq_r <= SUMSQ_W'(sq_x) + SUMSQ_W'(sq_y);
      step_r  <= STEP_W'(CH_W - 1);
      res_r   <= '0;
    end else if (state_r == M_ROOT) begin
      if (fits) begin
        res_r <= trial;
      end
      step_r <= step_r - STEP_W'(1);
    end
  end

endmodule
